[hdl/kyg_pkg.sv]
// Shared constants, word types and state encodings for the Knuth-Yao sampler.
`timescale 1ns / 1ps

package kyg_pkg;

	localparam int unsigned DEF_MAX_ROWS       = 64;
	localparam int unsigned DEF_PRECISION_BITS = 128;

	localparam int unsigned SAMPLE_W    = 7;
	localparam int unsigned LOAD_ROW_W  = 6;
	localparam int unsigned BYTE_IDX_W  = 4;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned ROWS_CFG_W  = 7;
	localparam int unsigned POLY_W      = 16;
	localparam int unsigned DIST_W      = 9;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd64;
	localparam logic [POLY_W-1:0]     SPP_RESET  = 16'd1024;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_BIT  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_IN_USE      = 1'b0,
		REG_SAMPLES_PER_POLY = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                  mode;
		logic [LOAD_ROW_W-1:0] load_row;
		logic [BYTE_IDX_W-1:0] load_byte_index;
		logic [BYTE_W-1:0]     load_byte;
		logic                  random_bit;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic                       last_of_poly;
		logic                       overflow;
	} out_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_word_t;

	typedef struct packed {
		logic start;
		logic random_bit;
	} walk_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} walk_rsp_t;

	typedef enum logic [3:0] {
		W_IDLE   = 4'b0001,
		W_FETCH  = 4'b0010,
		W_SCAN   = 4'b0100,
		W_COLEND = 4'b1000
	} walk_state_t;

endpackage

[hdl/kyg_chan_if.sv]
// Valid/ready channel interface carrying one word of a given type.
`timescale 1ns / 1ps

interface kyg_chan_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hdl/kyg_prob_mem.sv]
// Probability matrix byte memory, one write port and one registered read port.
`timescale 1ns / 1ps

module kyg_prob_mem import kyg_pkg::*; #(
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned ADDR_W = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/kyg_walk.sv]
// Tree walk engine: one matrix row per cycle through a shared distance subtractor.
`timescale 1ns / 1ps

module kyg_walk import kyg_pkg::*; #(
	parameter int unsigned MAX_ROWS       = DEF_MAX_ROWS,
	parameter int unsigned PRECISION_BITS = DEF_PRECISION_BITS,
	localparam int unsigned ROW_W     = $clog2(MAX_ROWS),
	localparam int unsigned CNT_W     = $clog2(MAX_ROWS + 1),
	localparam int unsigned COL_W     = $clog2(PRECISION_BITS),
	localparam int unsigned ROW_BYTES = (PRECISION_BITS + 7) / 8,
	localparam int unsigned ADDR_W    = $clog2(MAX_ROWS * ROW_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  walk_req_t         req,
	input  logic [CNT_W-1:0]  rows,
	output walk_rsp_t         rsp,
	output logic [ROW_W-1:0]  hit_row,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [BYTE_W-1:0] rd_data
);

	walk_state_t       state_q;
	logic [DIST_W-1:0] dist_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic             cur_bit;
	logic             hit;
	logic             last_col;
	logic [ROW_W-1:0] rd_row;

	// column c sits at bit 7 - (c mod 8) of its byte
	assign cur_bit  = rd_data[~col_q[2:0]];
	assign hit      = cur_bit && (dist_q == '0);
	assign last_col = (col_q == COL_W'(PRECISION_BITS - 1));

	assign rd_row  = (state_q == W_FETCH) ? row_q : row_q - 1'b1;
	assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(ROW_BYTES) + ADDR_W'(col_q >> 3);
	assign rd_en   = (state_q == W_FETCH) || ((state_q == W_SCAN) && (row_q != '0));

	assign rsp.busy = (state_q != W_IDLE);
	assign rsp.done = ((state_q == W_SCAN) && hit) || ((state_q == W_COLEND) && last_col);
	assign rsp.hit  = (state_q == W_SCAN);
	assign hit_row  = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			dist_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (req.start) begin
						// saturate at the top of the distance range
						if (dist_q[DIST_W-1]) begin
							dist_q <= '1;
						end else begin
							dist_q <= {dist_q[DIST_W-2:0], ~req.random_bit};
						end
						if (rows == '0) begin
							state_q <= W_COLEND;
						end else begin
							row_q   <= ROW_W'(rows - 1'b1);
							state_q <= W_FETCH;
						end
					end
				end
				W_FETCH: begin
					state_q <= W_SCAN;
				end
				W_SCAN: begin
					if (hit) begin
						dist_q  <= '0;
						col_q   <= '0;
						state_q <= W_IDLE;
					end else begin
						dist_q <= dist_q - DIST_W'(cur_bit);
						if (row_q == '0) begin
							state_q <= W_COLEND;
						end else begin
							row_q <= row_q - 1'b1;
						end
					end
				end
				W_COLEND: begin
					if (last_col) begin
						col_q  <= '0;
						dist_q <= '0;
					end else begin
						col_q <= col_q + 1'b1;
					end
					state_q <= W_IDLE;
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/knuth_yao_gaussian_sampler.sv]
// Top level of the Knuth-Yao discrete Gaussian sampler.
// Each input word either loads one byte of the probability matrix (mode 0) or
// supplies one random bit (mode 1). rows_in_use is capped at MAX_ROWS. The
// matrix memory has one read port and the distance has one subtractor, so a
// random bit that steps the walk is accepted in the idle state, then a fetch
// state covers the read latency, the rows of the current column are scanned one
// per cycle and a column-end state does the column bookkeeping; a hit ends the
// scan early. The bit after a hit gives the sign, and the sample is registered
// into the output register. Passing the last column yields an overflow word
// and restarts the walk. Matrix bytes hold no defined value until loaded;
// there is no clearing pass, so load every byte the walk can reach first.
// Results wait in an output register; a new word is taken once the walk is
// idle and that register is free or being drained.
`timescale 1ns / 1ps

module knuth_yao_gaussian_sampler import kyg_pkg::*; #(
	parameter int unsigned MAX_ROWS       = DEF_MAX_ROWS,
	parameter int unsigned PRECISION_BITS = DEF_PRECISION_BITS
) (
	input logic        clk,
	input logic        arst_n,
	kyg_chan_if.sink   item,
	kyg_chan_if.source result,
	kyg_chan_if.sink   cfg
);

	localparam int unsigned ROW_W     = $clog2(MAX_ROWS);
	localparam int unsigned CNT_W     = $clog2(MAX_ROWS + 1);
	localparam int unsigned ROW_BYTES = (PRECISION_BITS + 7) / 8;
	localparam int unsigned DEPTH     = MAX_ROWS * ROW_BYTES;
	localparam int unsigned ADDR_W    = $clog2(DEPTH);

	logic [ROWS_CFG_W-1:0] rows_in_use_q;
	logic [POLY_W-1:0]     samples_per_poly_q;
	logic [POLY_W-1:0]     sample_count_q;
	logic                  awaiting_sign_q;
	logic [ROW_W-1:0]      hit_row_q;
	logic                  out_valid_q;
	out_word_t             out_word_q;

	in_word_t         in_w;
	cfg_word_t        cfg_w;
	logic             accept;
	logic             sign_step;
	logic             mem_wr;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic             mem_rd;
	logic [ADDR_W-1:0] mem_rd_addr;
	logic [BYTE_W-1:0] mem_rd_data;
	walk_req_t        walk_req;
	walk_rsp_t        walk_rsp;
	logic [ROW_W-1:0] walk_hit_row;
	logic [CNT_W-1:0] rows_eff;

	logic [SAMPLE_W-1:0] magnitude;
	logic [POLY_W-1:0]   next_count;
	logic                last;

	assign in_w  = item.data;
	assign cfg_w = cfg.data;

	assign item.ready = !walk_rsp.busy && (!out_valid_q || result.ready);
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;

	assign mem_wr = accept && (in_w.mode == MODE_LOAD) && (int'(in_w.load_row) < MAX_ROWS)
		&& (int'(in_w.load_byte_index) < ROW_BYTES);
	assign mem_wr_addr = ADDR_W'(in_w.load_row) * ADDR_W'(ROW_BYTES)
		+ ADDR_W'(in_w.load_byte_index);

	assign sign_step           = accept && (in_w.mode == MODE_BIT) && awaiting_sign_q;
	assign walk_req.start      = accept && (in_w.mode == MODE_BIT) && !awaiting_sign_q;
	assign walk_req.random_bit = in_w.random_bit;

	assign rows_eff = (int'(rows_in_use_q) > MAX_ROWS) ? CNT_W'(MAX_ROWS)
		: CNT_W'(rows_in_use_q);

	assign magnitude  = SAMPLE_W'(hit_row_q);
	assign next_count = sample_count_q + 1'b1;
	assign last       = (next_count == samples_per_poly_q);

	kyg_prob_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (mem_wr_addr),
		.wr_data (in_w.load_byte),
		.rd_en   (mem_rd),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	kyg_walk #(
		.MAX_ROWS       (MAX_ROWS),
		.PRECISION_BITS (PRECISION_BITS)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (walk_req),
		.rows    (rows_eff),
		.rsp     (walk_rsp),
		.hit_row (walk_hit_row),
		.rd_en   (mem_rd),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q      <= ROWS_RESET;
			samples_per_poly_q <= SPP_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg_w.index))
				REG_ROWS_IN_USE:      rows_in_use_q      <= cfg_w.value[ROWS_CFG_W-1:0];
				REG_SAMPLES_PER_POLY: samples_per_poly_q <= cfg_w.value;
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_sign_q <= 1'b0;
			hit_row_q       <= '0;
			sample_count_q  <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (walk_rsp.done && walk_rsp.hit) begin
				awaiting_sign_q <= 1'b1;
				hit_row_q       <= walk_hit_row;
			end else if (sign_step) begin
				awaiting_sign_q <= 1'b0;
			end

			if (sign_step) begin
				sample_count_q <= last ? '0 : next_count;
			end

			if (sign_step || (walk_rsp.done && !walk_rsp.hit)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sign_step) begin
			out_word_q.sample_value <= in_w.random_bit ? magnitude : -magnitude;
			out_word_q.last_of_poly <= last;
			out_word_q.overflow     <= 1'b0;
		end else if (walk_rsp.done && !walk_rsp.hit) begin
			out_word_q.sample_value <= '0;
			out_word_q.last_of_poly <= 1'b0;
			out_word_q.overflow     <= 1'b1;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;

endmodule
